// ===== design/ltkm_pkg.sv =====
// ----------------------------------------------------------------------------
// ltkm_pkg
// Shared constants and entry types for the loser tree k-way merge.
// ----------------------------------------------------------------------------
package ltkm_pkg;

  localparam int K_WAYS = 8;
  localparam int WAY_W  = 3;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 32;
  // node address width and leaf index width (real leaves plus sentinel)
  localparam int LVL_W  = $clog2(K_WAYS);
  localparam int IDX_W  = $clog2(K_WAYS + 1);

  localparam logic [IDX_W-1:0] SENT_IDX = IDX_W'(K_WAYS);
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_REFILL = 1'b1;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [PAY_W-1:0] payload;
  } leaf_ent_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [KEY_W-1:0] key;
  } node_ent_t;

endpackage

// ===== design/loser_tree_kway_merge.sv =====
// ----------------------------------------------------------------------------
// loser_tree_kway_merge
// K-way merge head: loser tree held in two small synchronous memories.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries load and refill requests. A load
// writes the head record of one way into its leaf; the K-th load of a set
// builds the tree and produces the first winner. A refill replaces the
// current winner's leaf, replays its path to the root and produces the new
// winner. Output channel (out_valid/out_ready) carries one winner per
// producing request; is_last marks the end-of-run key, after which refills
// are dropped. Refills before the tree is built are dropped as well.
// A load that does not complete a set only writes its leaf. A refill does
// one node memory read-compare-write per tree level, then one leaf memory
// read for the winner record. A set-completing load replays the K leaves,
// each a leaf read plus one node step per level, then reads the winner record.
// The result sits in an output register; in_ready stays low until it has
// been placed there, so a stalled receiver holds the walk in its last step.
// Reset (rst, synchronous) clears the load count, built and done flags and
// the node valid bits; the memory contents are left as they are.
// ----------------------------------------------------------------------------
module loser_tree_kway_merge
  import ltkm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic [WAY_W-1:0]        way,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [PAY_W-1:0] payload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WAY_W-1:0]        winner_way,
  output logic signed [KEY_W-1:0] winner_key,
  output logic signed [PAY_W-1:0] winner_payload,
  output logic                    is_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEAF = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // first node on the path from leaf s: (s + K) / 2
  function automatic logic [LVL_W-1:0] path_start(input logic [IDX_W-1:0] s);
    logic [IDX_W:0] sum;
    sum = {1'b0, s} + (IDX_W+1)'(K_WAYS);
    return sum[LVL_W:1];
  endfunction

  // storage
  leaf_ent_t leaf_mem [K_WAYS];
  node_ent_t node_mem [K_WAYS];
  leaf_ent_t leaf_q;
  node_ent_t node_q;
  logic [K_WAYS-1:0] node_vld;

  // control
  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] cnt;
  logic             built;
  logic             done;
  logic             bld;
  logic             first;
  logic [LVL_W-1:0] bld_i;
  logic [LVL_W-1:0] t;
  logic [IDX_W-1:0] s_idx;
  logic signed [KEY_W-1:0] s_key;
  logic [IDX_W-1:0] root_idx;

  // handshake terms
  logic in_xfer;
  logic is_load;
  logic load_ok;
  logic refill_ok;
  logic set_full;
  logic [IDX_W-1:0] cnt_inc;

  // walk datapath
  logic [IDX_W-1:0]        c_idx;
  logic signed [KEY_W-1:0] c_key;
  logic [IDX_W-1:0]        o_idx;
  logic signed [KEY_W-1:0] o_key;
  logic                    c_loses;
  logic [IDX_W-1:0]        w_idx;
  logic signed [KEY_W-1:0] w_key;
  logic [LVL_W-1:0]        t_up;
  logic                    at_root;
  logic                    walk_end;

  logic [LVL_W-1:0] node_raddr;
  logic             leaf_ren;
  logic [LVL_W-1:0] leaf_raddr;
  logic             out_load;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign is_load   = (req_type == REQ_LOAD);
  assign load_ok   = is_load && ((IDX_W+1)'(way) < (IDX_W+1)'(K_WAYS));
  assign refill_ok = !is_load && built && !done && (root_idx != SENT_IDX);
  assign cnt_inc   = (built ? '0 : cnt) + IDX_W'(1);
  assign set_full  = (cnt_inc >= SENT_IDX);

  // climbing entry versus the loser stored at node t
  always_comb begin
    c_idx   = first ? IDX_W'(bld_i) : s_idx;
    c_key   = first ? leaf_q.key : s_key;
    o_idx   = node_vld[t] ? node_q.idx : SENT_IDX;
    o_key   = node_q.key;
    c_loses = (c_idx != SENT_IDX) && ((o_idx == SENT_IDX) || (c_key > o_key));
    w_idx   = c_loses ? o_idx : c_idx;
    w_key   = c_loses ? o_key : c_key;
    t_up    = t >> 1;
    at_root = (t_up == '0);
    walk_end = (state == ST_WALK) && at_root && !(bld && (bld_i != '0));
  end

  // read addresses: path start for a refill or a build leaf, else next level
  always_comb begin
    case (state)
      ST_IDLE: node_raddr = path_start(root_idx);
      ST_LEAF: node_raddr = path_start(IDX_W'(bld_i));
      default: node_raddr = t_up;
    endcase
    leaf_ren   = (state == ST_LEAF) || walk_end;
    leaf_raddr = (state == ST_LEAF) ? bld_i : LVL_W'(w_idx);
  end

  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (load_ok && set_full) state_next = ST_LEAF;
          else if (refill_ok)      state_next = ST_WALK;
        end
      end
      ST_LEAF: state_next = ST_WALK;
      ST_WALK: begin
        if (at_root) state_next = walk_end ? ST_OUT : ST_LEAF;
      end
      ST_OUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memories: leaf written on transfer, node written when the climber loses
  always_ff @(posedge clk) begin
    if (in_xfer && (load_ok || refill_ok)) begin
      if (load_ok) leaf_mem[LVL_W'(way)] <= '{key: key, payload: payload};
      else         leaf_mem[LVL_W'(root_idx)] <= '{key: key, payload: payload};
    end
    if (leaf_ren) leaf_q <= leaf_mem[leaf_raddr];
    if ((state == ST_WALK) && c_loses) node_mem[t] <= '{idx: c_idx, key: c_key};
    node_q <= node_mem[node_raddr];
  end

  // walk registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer && refill_ok) begin
          s_idx <= root_idx;
          s_key <= key;
          t     <= path_start(root_idx);
        end
      end
      ST_LEAF: t <= path_start(IDX_W'(bld_i));
      ST_WALK: begin
        s_idx <= w_idx;
        s_key <= w_key;
        t     <= t_up;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      built     <= 1'b0;
      done      <= 1'b0;
      bld       <= 1'b0;
      first     <= 1'b0;
      bld_i     <= '0;
      root_idx  <= SENT_IDX;
      node_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // load the result register, else drop valid once the result is taken
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_xfer && load_ok) begin
            // a load after a built tree opens a new set
            if (set_full) begin
              cnt      <= '0;
              built    <= 1'b1;
              done     <= 1'b0;
              bld      <= 1'b1;
              bld_i    <= LVL_W'(K_WAYS - 1);
              node_vld <= '0;
            end else begin
              cnt   <= cnt_inc;
              built <= 1'b0;
              done  <= 1'b0;
            end
          end
        end
        ST_LEAF: first <= 1'b1;
        ST_WALK: begin
          first <= 1'b0;
          if (c_loses) node_vld[t] <= 1'b1;
          if (at_root) begin
            root_idx <= w_idx;
            if (bld && (bld_i != '0)) bld_i <= bld_i - LVL_W'(1);
            else                      bld   <= 1'b0;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if ((root_idx != SENT_IDX) && (leaf_q.key == KEY_MAX)) done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register; a sentinel root reads as an empty record
  always_ff @(posedge clk) begin
    if (out_load) begin
      winner_way <= WAY_W'(root_idx);
      if (root_idx == SENT_IDX) begin
        winner_key     <= '0;
        winner_payload <= '0;
        is_last        <= 1'b0;
      end else begin
        winner_key     <= leaf_q.key;
        winner_payload <= leaf_q.payload;
        is_last        <= (leaf_q.key == KEY_MAX);
      end
    end
  end

  a_walk_node: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (t != '0))
    else $error("walk reached node zero");

  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result not registered");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < SENT_IDX)
    else $error("load count out of range");

  a_root_real: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (root_idx != SENT_IDX))
    else $error("sentinel reached the root");

  a_build_first: assert property (@(posedge clk) disable iff (rst)
    first |-> (bld && (state == ST_WALK)))
    else $error("leaf operand used outside a build walk");

endmodule

// ===== verif/ltkm_merge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltkm_merge_checker
// Watches both channels of the loser tree merge, keeps its own copy of the
// leaves and loser nodes, predicts each winner and compares every output
// transfer field by field against the oldest pending winner.
// ----------------------------------------------------------------------------
module ltkm_merge_checker
  import ltkm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    req_type,
  input  logic [WAY_W-1:0]        way,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [PAY_W-1:0] payload,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [WAY_W-1:0]        winner_way,
  input  logic signed [KEY_W-1:0] winner_key,
  input  logic signed [PAY_W-1:0] winner_payload,
  input  logic                    is_last,
  output int unsigned             fail_count,
  output int unsigned             pending
);

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  typedef struct packed {
    logic [WAY_W-1:0]        way;
    logic signed [KEY_W-1:0] key;
    logic signed [PAY_W-1:0] pay;
    logic                    last;
  } winner_t;

  // leaf K_WAYS is the minimum sentinel used while building
  logic signed [KEY_W-1:0] head_key [0:K_WAYS];
  logic signed [PAY_W-1:0] head_pay [0:K_WAYS-1];
  logic [IDX_W-1:0]        loser    [0:K_WAYS-1];
  int unsigned             loads_in_set;
  bit                      tree_ready;
  bit                      run_over;
  winner_t                 winners_due [$];
  int unsigned             errs = 0;

  // strictly greater key loses; the sentinel never loses
  function automatic bit climber_loses(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
    if (a == SENT_IDX) return 1'b0;
    if (b == SENT_IDX) return 1'b1;
    return head_key[a] > head_key[b];
  endfunction

  task automatic replay_path(input logic [IDX_W-1:0] leaf);
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] other;
    int               t;
    s = leaf;
    t = (int'(leaf) + K_WAYS) / 2;
    while (t > 0) begin
      other = loser[t];
      if (climber_loses(s, other)) begin
        loser[t] = s;
        s = other;
      end
      t = t / 2;
    end
    loser[0] = s;
  endtask

  task automatic rebuild_tree();
    head_key[K_WAYS] = KEY_MIN;
    for (int i = 0; i < K_WAYS; i++) loser[i] = SENT_IDX;
    for (int i = K_WAYS - 1; i >= 0; i--) replay_path(IDX_W'(i));
  endtask

  task automatic post_winner();
    winner_t          w;
    logic [IDX_W-1:0] top;
    top = loser[0];
    w.way = top[WAY_W-1:0];
    w.key = '0;
    w.pay = '0;
    if (top < SENT_IDX) begin
      w.key = head_key[top];
      w.pay = head_pay[top];
    end
    w.last = (w.key == KEY_MAX);
    if (w.last) run_over = 1'b1;
    winners_due.push_back(w);
  endtask

  task automatic absorb_request(input logic rt, input logic [WAY_W-1:0] w,
                                input logic signed [KEY_W-1:0] k,
                                input logic signed [PAY_W-1:0] p);
    logic [IDX_W-1:0] top;
    if (rt == REQ_LOAD) begin
      if (int'(w) >= K_WAYS) return;
      // a load into a built tree starts a new set
      if (tree_ready) begin
        tree_ready   = 1'b0;
        run_over     = 1'b0;
        loads_in_set = 0;
      end
      head_key[w] = k;
      head_pay[w] = p;
      loads_in_set++;
      if (loads_in_set >= K_WAYS) begin
        loads_in_set = 0;
        rebuild_tree();
        tree_ready = 1'b1;
        run_over   = 1'b0;
        post_winner();
      end
    end else begin
      if (!tree_ready || run_over) return;
      top = loser[0];
      if (top >= SENT_IDX) return;
      head_key[top] = k;
      head_pay[top] = p;
      replay_path(top);
      post_winner();
    end
  endtask

  always @(posedge clk) begin : watch
    winner_t exp_w;
    if (rst) begin
      for (int i = 0; i <= K_WAYS; i++) head_key[i] = '0;
      for (int i = 0; i < K_WAYS; i++) begin
        head_pay[i] = '0;
        loser[i]    = '0;
      end
      loads_in_set = 0;
      tree_ready   = 1'b0;
      run_over     = 1'b0;
      winners_due.delete();
    end else begin
      // check the output transfer first: it belongs to an earlier request
      if (out_valid && out_ready) begin
        if (winners_due.size() == 0) begin
          $display("%0t: winner with none expected, actual way %0d key %0d payload %0d last %0d",
                   $time, winner_way, winner_key, winner_payload, is_last);
          errs++;
        end else begin
          exp_w = winners_due.pop_front();
          if (winner_way !== exp_w.way) begin
            $display("%0t: winner_way expected %0d actual %0d", $time, exp_w.way, winner_way);
            errs++;
          end
          if (winner_key !== exp_w.key) begin
            $display("%0t: winner_key expected %0d actual %0d", $time, exp_w.key, winner_key);
            errs++;
          end
          if (winner_payload !== exp_w.pay) begin
            $display("%0t: winner_payload expected %0d actual %0d",
                     $time, exp_w.pay, winner_payload);
            errs++;
          end
          if (is_last !== exp_w.last) begin
            $display("%0t: is_last expected %0d actual %0d", $time, exp_w.last, is_last);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) absorb_request(req_type, way, key, payload);
    end
    fail_count <= errs;
    pending    <= winners_due.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the loser tree k-way merge: directed loads and
// refills first, then randomized merges of sorted runs with ties, early
// restarts and dropped requests, under three idle patterns and a long
// receiver hold. Checking lives in ltkm_merge_checker.
// ----------------------------------------------------------------------------
module tb;
  import ltkm_pkg::*;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam int unsigned ITEM_GOAL   = 950;
  localparam int unsigned PHASE2_AT   = 320;
  localparam int unsigned PHASE3_AT   = 640;
  localparam int unsigned HOLD_AFTER  = 120;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 50;

  typedef enum int {MODE_TIES, MODE_SPREAD, MODE_NOISE} key_mode_e;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    req_type = REQ_LOAD;
  logic [WAY_W-1:0]        way = '0;
  logic signed [KEY_W-1:0] key = '0;
  logic signed [PAY_W-1:0] payload = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [WAY_W-1:0]        winner_way;
  logic signed [KEY_W-1:0] winner_key;
  logic signed [PAY_W-1:0] winner_payload;
  logic                    is_last;
  int unsigned             fail_count;
  int unsigned             pending;

  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 58;

  // Light shadow of the merge, only what is needed to shape stimulus:
  // which requests will be acted on, and how many ways still hold a key
  // below the end marker.
  bit               head_max [0:K_WAYS-1];
  bit               heads_known = 1'b0;
  bit               tree_up = 1'b0;
  bit               merge_over = 1'b0;
  int               loads_seen = 0;
  int               live_ways = 0;
  logic [K_WAYS-1:0] set_mask = '0;
  int unsigned      live_items = 0;
  key_mode_e        key_mode = MODE_TIES;
  logic signed [KEY_W-1:0] key_base = '0;
  logic signed [KEY_W-1:0] key_floor = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  loser_tree_kway_merge uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .way            (way),
    .key            (key),
    .payload        (payload),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .winner_way     (winner_way),
    .winner_key     (winner_key),
    .winner_payload (winner_payload),
    .is_last        (is_last)
  );

  ltkm_merge_checker merge_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .way            (way),
    .key            (key),
    .payload        (payload),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .winner_way     (winner_way),
    .winner_key     (winner_key),
    .winner_payload (winner_payload),
    .is_last        (is_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Receiver: random back-pressure, plus one long hold once enough output
  // transfers have gone by. The sender keeps offering during the hold, so
  // the output register fills and in_ready drops.
  int unsigned rx_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready) rx_seen++;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_used && rx_seen >= HOLD_AFTER) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one item and return in the step of its transfer. In_valid stays
  // high afterward; the caller either offers the next item at once or drops it.
  task automatic offer(input logic rt, input logic [WAY_W-1:0] w,
                       input logic signed [KEY_W-1:0] k,
                       input logic signed [PAY_W-1:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    way      <= w;
    key      <= k;
    payload  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_load(input logic [WAY_W-1:0] w, input logic signed [KEY_W-1:0] k,
                           input logic signed [PAY_W-1:0] p);
    offer(REQ_LOAD, w, k, p);
    if (tree_up) begin
      tree_up    = 1'b0;
      merge_over = 1'b0;
      loads_seen = 0;
      set_mask   = '0;
    end
    head_max[w] = (k == KEY_MAX);
    set_mask[w] = 1'b1;
    loads_seen++;
    live_items++;
    if (loads_seen == K_WAYS) begin
      // set complete: the tree gets built and the first winner comes out
      loads_seen = 0;
      tree_up    = 1'b1;
      if (set_mask == '1) heads_known = 1'b1;
      set_mask  = '0;
      live_ways = 0;
      for (int i = 0; i < K_WAYS; i++) if (!head_max[i]) live_ways++;
      merge_over = (live_ways == 0);
    end
  endtask

  task automatic send_refill(input logic signed [KEY_W-1:0] k,
                             input logic signed [PAY_W-1:0] p);
    bit acted;
    acted = tree_up && !merge_over;
    // way is don't-care on a refill; randomize it anyway
    offer(REQ_REFILL, WAY_W'($urandom), k, p);
    if (acted) begin
      live_items++;
      heads_known = 1'b0;
      // the winner is always a live way, so an end marker retires one
      if (k == KEY_MAX) begin
        live_ways--;
        if (live_ways == 0) begin
          merge_over  = 1'b1;
          heads_known = 1'b1;
          for (int i = 0; i < K_WAYS; i++) head_max[i] = 1'b1;
        end
      end
    end
  endtask

  // Loads sit just above the base; refills climb from the highest key so far,
  // so every way's run stays sorted. Noise mode throws the order away.
  task automatic draw_key(input bit refill, output logic signed [KEY_W-1:0] k);
    longint v;
    case (key_mode)
      MODE_TIES: begin
        v = refill ? longint'(key_floor) + longint'($urandom_range(1))
                   : longint'(key_base) + longint'($urandom_range(3));
      end
      MODE_SPREAD: begin
        v = refill ? longint'(key_floor) + longint'($urandom_range(1 << 20))
                   : longint'(key_base) + longint'($urandom_range(1 << 24));
      end
      default: begin
        v = longint'($signed($urandom));
      end
    endcase
    if (v > longint'(KEY_MAX) - 1) v = longint'(KEY_MAX) - 1;
    if (v < longint'(KEY_MIN) + 1) v = longint'(KEY_MIN) + 1;
    k = KEY_W'(v);
    if (key_mode != MODE_NOISE && k > key_floor) key_floor = k;
  endtask

  // One merge: a set of loads, a run of refills, usually drained to the end
  // marker, sometimes cut short by the next set.
  task automatic run_merge();
    int                      order [K_WAYS];
    int                      pick;
    int                      tmp;
    int                      n_plain;
    int                      r;
    bit                      dup;
    bit                      all_end;
    bit                      abort_early;
    logic [WAY_W-1:0]        w;
    logic signed [KEY_W-1:0] k;
    r = $urandom_range(9);
    if (r < 4) key_mode = MODE_TIES;
    else if (r < 8) key_mode = MODE_SPREAD;
    else key_mode = MODE_NOISE;
    key_base  = ($urandom_range(7) == 0) ? KEY_MIN + 1 : $signed($urandom);
    if (key_base == KEY_MIN) key_base = KEY_MIN + 1;
    key_floor = key_base;
    for (int i = 0; i < K_WAYS; i++) order[i] = i;
    for (int i = K_WAYS - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    // a repeated load leaves the last way of the shuffle untouched, so only
    // do it when that way's head is already known
    dup         = heads_known && ($urandom_range(3) == 0);
    pick        = $urandom_range(K_WAYS - 2);
    all_end     = ($urandom_range(39) == 0);
    abort_early = ($urandom_range(7) == 0);
    for (int n = 0; n < K_WAYS; n++) begin
      if (dup) w = (n == 0) ? WAY_W'(order[pick]) : WAY_W'(order[n-1]);
      else w = WAY_W'(order[n]);
      if (all_end || $urandom_range(7) == 0) k = KEY_MAX;
      else draw_key(1'b0, k);
      send_load(w, k, $urandom);
      // a refill in the middle of a set must be dropped
      if (n == 0 && $urandom_range(5) == 0) send_refill($signed($urandom) | 32'sd1, $urandom);
    end
    n_plain = $urandom_range(14);
    while (!merge_over) begin
      if (abort_early && $urandom_range(3) == 0) break;
      if (n_plain > 0 && $urandom_range(3) != 0) begin
        draw_key(1'b1, k);
        n_plain--;
      end else begin
        k = KEY_MAX;
      end
      send_refill(k, $urandom);
    end
    // refills after the last winner must be dropped
    if (merge_over && $urandom_range(3) == 0) send_refill(KEY_MAX - 1, $urandom);
  endtask

  // Drop valid and hold until the checker has nothing outstanding.
  task automatic hush_until_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic directed_items();
    // refill before any tree exists: dropped
    send_refill(32'sd12345, 32'sd678);
    // first set: extremes of key and payload, equal keys, empty ways
    send_load(3'd7, KEY_MIN + 1,    32'sh8000_0000);
    send_load(3'd6, KEY_MAX - 1,    32'sh7FFF_FFFF);
    send_load(3'd5, KEY_MAX,        32'sd0);
    send_load(3'd4, KEY_MAX,        -32'sd1);
    send_load(3'd3, 32'sd0,         32'sh5555_5555);
    send_load(3'd2, 32'sd0,         32'shAAAA_AAAA);
    send_load(3'd1, KEY_MAX,        32'sd1);
    send_load(3'd0, -32'sd1,        32'sh0F0F_0F0F);
    // refill with a key tied against two leaves, then drain every live way
    send_refill(32'sd0, 32'sh1234_5678);
    repeat (5) send_refill(KEY_MAX, $urandom);
    // merge is over: dropped
    send_refill(32'sd99, 32'sd99);
    // second set into the finished tree, with way 3 loaded twice
    send_load(3'd3, 32'sd500,       32'sd3);
    send_load(3'd3, -32'sd5,        32'sd33);
    send_load(3'd0, -32'sd5,        32'sd10);
    send_load(3'd1, 32'sd7,         32'sd11);
    send_load(3'd2, KEY_MIN + 1,    32'sd12);
    send_load(3'd4, KEY_MAX - 1,    32'sd14);
    send_load(3'd5, -32'sd5,        32'sd15);
    send_load(3'd6, 32'sd7,         32'sd16);
  endtask

  initial begin : stimulus
    int phase;
    phase = 0;
    for (int i = 0; i < K_WAYS; i++) head_max[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    directed_items();
    while (live_items < ITEM_GOAL) begin
      // switch idle pattern between merges, after letting the block empty
      if (phase == 0 && live_items >= PHASE2_AT) begin
        hush_until_empty();
        tx_idle_pct = 58;
        rx_idle_pct <= 11;
        phase = 1;
      end else if (phase == 1 && live_items >= PHASE3_AT) begin
        hush_until_empty();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        phase = 2;
      end
      run_merge();
    end
    hush_until_empty();
    // give a stray extra result time to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
